@@ hdl/hsrr_pkg.sv @@
package hsrr_pkg;

    // fixed point format of t and of the divisor
    localparam int FRAC_BITS = 15;
    localparam int TCW       = FRAC_BITS + 1;          // clamped t, 0..1.0
    localparam int PW        = 2 * TCW;                // product width
    localparam int DW        = FRAC_BITS + 2;          // divisor, up to 3.0
    localparam int DSW       = FRAC_BITS + 5;          // signed divisor work width
    localparam int MW        = 8;                      // pixel / magnitude width
    localparam int QB        = 9;                      // quotient bits kept
    localparam int NW        = MW + FRAC_BITS;         // numerator width
    localparam int CMPW      = DW + QB + 1;            // compare width in the divider

    // queue between front and back, depth is a power of two
    localparam int Q_AW      = 2;
    localparam int Q_DEPTH   = 1 << Q_AW;

    localparam logic [TCW-1:0] ONE_Q = TCW'(1) << FRAC_BITS;
    localparam longint KNEE_L =
        (64'd859734 * (64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [TCW-1:0] BOOST_KNEE = TCW'(KNEE_L);

    // configuration register indexes
    localparam logic [2:0] REG_AIR_RED   = 3'd0;
    localparam logic [2:0] REG_AIR_GREEN = 3'd1;
    localparam logic [2:0] REG_AIR_BLUE  = 3'd2;
    localparam logic [2:0] REG_BOOST     = 3'd3;
    localparam logic [2:0] REG_LOW_LIGHT = 3'd4;

    // one channel of I - A as sign and magnitude
    typedef struct packed {
        logic          neg;
        logic [MW-1:0] mag;
    } diff_t;

    // item handed from the front part to the back part
    typedef struct packed {
        logic [DW-1:0] div;
        diff_t [2:0]   diff;
    } work_t;

    // queue status toward the front part
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

@@ hdl/hsrr_front.sv @@
module hsrr_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                pix_red,
    input  logic [7:0]                pix_green,
    input  logic [7:0]                pix_blue,
    input  logic [15:0]               transmission,
    input  logic [2:0][7:0]           airlight,
    input  logic                      boost_enable,
    input  logic                      low_light_mode,
    input  hsrr_pkg::queue_stat_t     q_stat,
    output logic                      push,
    output hsrr_pkg::work_t           push_data
);

    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [hsrr_pkg::TCW-1:0]      t1_reg, t2_reg, t3_reg;
    logic [hsrr_pkg::PW-1:0]       tt2_reg, tt3_reg, ttt3_reg;
    hsrr_pkg::diff_t [2:0]         d1_reg, d2_reg, d3_reg;
    hsrr_pkg::work_t               w4_reg;
    logic                          adv;
    logic [hsrr_pkg::TCW-1:0]      t_clamp;
    logic [2:0][7:0]               pix_in;
    hsrr_pkg::diff_t [2:0]         diff_in;
    logic signed [hsrr_pkg::DSW-1:0] d_lin, d_hi, d_lo, d_sel;
    logic [hsrr_pkg::TCW-1:0]      t3q;

    // whole front pipeline stalls only when its last item cannot enter the queue
    assign adv      = !(v4_reg && q_stat.full);
    assign in_ready = adv;
    assign push     = v4_reg && !q_stat.full;
    assign push_data = w4_reg;

    // clamp t and form I - A per channel (I inverted in low light mode)
    always_comb begin
        t_clamp = (32'(transmission) > 32'(hsrr_pkg::ONE_Q)) ? hsrr_pkg::ONE_Q
                                                              : hsrr_pkg::TCW'(transmission);
        pix_in = {pix_blue, pix_green, pix_red};
        for (int c = 0; c < 3; c++) begin
            logic [7:0] p;
            p = low_light_mode ? (8'd255 - pix_in[c]) : pix_in[c];
            diff_in[c].neg = p < airlight[c];
            diff_in[c].mag = (p < airlight[c]) ? (airlight[c] - p) : (p - airlight[c]);
        end
    end

    // divisor from t, plain or boosted
    always_comb begin
        t3q   = hsrr_pkg::TCW'(ttt3_reg >> hsrr_pkg::FRAC_BITS);
        d_lin = hsrr_pkg::DSW'(t3_reg);
        d_lo  = hsrr_pkg::DSW'(tt3_reg >> (hsrr_pkg::FRAC_BITS - 1));
        d_hi  = (hsrr_pkg::DSW'(t3_reg) <<< 3) - hsrr_pkg::DSW'(3 * hsrr_pkg::ONE_Q)
              - (hsrr_pkg::DSW'(t3q) <<< 1);
        if (!boost_enable) begin
            d_sel = d_lin;
        end else if (t3_reg <= hsrr_pkg::BOOST_KNEE) begin
            d_sel = d_lo;
        end else begin
            d_sel = d_hi;
        end
        if (d_sel < 0) begin
            d_sel = '0;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload: t^2 then t^3, then the divisor
    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg   <= t_clamp;
            d1_reg   <= diff_in;
            t2_reg   <= t1_reg;
            d2_reg   <= d1_reg;
            tt2_reg  <= t1_reg * t1_reg;
            t3_reg   <= t2_reg;
            d3_reg   <= d2_reg;
            tt3_reg  <= tt2_reg;
            ttt3_reg <= hsrr_pkg::TCW'(tt2_reg >> hsrr_pkg::FRAC_BITS) * t2_reg;
            w4_reg.div  <= hsrr_pkg::DW'(d_sel);
            w4_reg.diff <= d3_reg;
        end
    end

endmodule

@@ hdl/hsrr_queue.sv @@
module hsrr_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  hsrr_pkg::work_t       push_data,
    input  logic                  pop,
    output hsrr_pkg::work_t       pop_data,
    output hsrr_pkg::queue_stat_t stat
);

    hsrr_pkg::work_t mem [hsrr_pkg::Q_DEPTH];
    logic [hsrr_pkg::Q_AW-1:0] wr_reg, rd_reg;
    logic [hsrr_pkg::Q_AW:0]   cnt_reg;
    logic                      do_push, do_pop;

    assign stat.full  = cnt_reg == (hsrr_pkg::Q_AW+1)'(hsrr_pkg::Q_DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + hsrr_pkg::Q_AW'(1);
            if (do_pop)  rd_reg <= rd_reg + hsrr_pkg::Q_AW'(1);
            cnt_reg <= cnt_reg + (hsrr_pkg::Q_AW+1)'(do_push)
                               - (hsrr_pkg::Q_AW+1)'(do_pop);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/hsrr_back.sv @@
module hsrr_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hsrr_pkg::queue_stat_t q_stat,
    input  hsrr_pkg::work_t       q_data,
    output logic                  pop,
    input  logic [2:0][7:0]       airlight,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0][7:0]       out_pix
);

    localparam int NS = hsrr_pkg::QB + 1;

    typedef struct packed {
        logic                     neg;
        logic                     sat;
        logic                     zero;
        logic [hsrr_pkg::NW-1:0]  rem;
        logic [hsrr_pkg::QB-1:0]  quo;
    } lane_t;

    lane_t [2:0]              ln_reg [NS];
    lane_t [2:0]              ln_next [NS];
    logic [hsrr_pkg::DW-1:0]  dv_reg [NS];
    logic [NS-1:0]            v_reg;
    logic                     ov_reg;
    logic [2:0][7:0]          op_reg;
    logic                     adv;
    logic [2:0][7:0]          res;

    assign adv       = !ov_reg || out_ready;
    assign pop       = adv && !q_stat.empty;
    assign out_valid = ov_reg;
    assign out_pix   = op_reg;

    // entry check and one restoring step per stage
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [hsrr_pkg::NW-1:0] n0;
            n0 = hsrr_pkg::NW'(q_data.diff[c].mag) << hsrr_pkg::FRAC_BITS;
            ln_next[0][c].neg  = q_data.diff[c].neg;
            ln_next[0][c].zero = q_data.diff[c].mag == '0;
            ln_next[0][c].sat  = hsrr_pkg::CMPW'(n0) >=
                                 (hsrr_pkg::CMPW'(q_data.div) << hsrr_pkg::QB);
            ln_next[0][c].rem  = n0;
            ln_next[0][c].quo  = '0;
        end
        for (int s = 1; s < NS; s++) begin
            for (int c = 0; c < 3; c++) begin
                logic [hsrr_pkg::CMPW-1:0] sh;
                sh = hsrr_pkg::CMPW'(dv_reg[s-1]) << (hsrr_pkg::QB - s);
                ln_next[s][c] = ln_reg[s-1][c];
                if (hsrr_pkg::CMPW'(ln_reg[s-1][c].rem) >= sh) begin
                    ln_next[s][c].rem = ln_reg[s-1][c].rem - hsrr_pkg::NW'(sh);
                    ln_next[s][c].quo[hsrr_pkg::QB-s] = 1'b1;
                end
            end
        end
    end

    // add the airlight back and clip
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            lane_t l;
            logic [hsrr_pkg::QB:0] qq;
            logic [hsrr_pkg::QB:0] sum;
            l   = ln_reg[NS-1][c];
            qq  = (hsrr_pkg::QB+1)'(l.quo) + (hsrr_pkg::QB+1)'(l.rem != '0);
            sum = (hsrr_pkg::QB+1)'(airlight[c]) + (hsrr_pkg::QB+1)'(l.quo);
            if (l.zero) begin
                res[c] = airlight[c];
            end else if (l.neg) begin
                res[c] = (l.sat || qq >= (hsrr_pkg::QB+1)'(airlight[c])) ? 8'd0
                         : 8'((hsrr_pkg::QB+1)'(airlight[c]) - qq);
            end else begin
                res[c] = (l.sat || sum > (hsrr_pkg::QB+1)'(255)) ? 8'd255 : 8'(sum);
            end
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end else if (adv) begin
            v_reg  <= {v_reg[NS-2:0], !q_stat.empty};
            ov_reg <= v_reg[NS-1];
        end
    end

    // divider stages and output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            ln_reg[0] <= ln_next[0];
            dv_reg[0] <= q_data.div;
            for (int s = 1; s < NS; s++) begin
                ln_reg[s] <= ln_next[s];
                dv_reg[s] <= dv_reg[s-1];
            end
            op_reg <= res;
        end
    end

endmodule

@@ hdl/haze_scene_radiance_recovery.sv @@
// channel   direction  tdata / tuser contents
// s_        in         tdata: pix_red, pix_green, pix_blue, transmission (40 bits)
// m_        out        tdata: out_red, out_green, out_blue (24 bits)
// cfg_      in         cfg_index 0..4 selects airlight r/g/b, boost, low light
//
// one item per clock sustained while m_tready stays high; from s_ to m_ an
// item passes 4 front stages (clamp, t^2, t^3, divisor), the queue,
// an entry check and 9 restoring steps (one quotient bit each, all three
// channels together) in the back part, then the output register.
// aresetn is synchronous; it empties the pipes and the queue and loads the
// airlight registers with 255. a stalled m_ side backs up the divider, then
// the queue, and only then drops s_tready.
module haze_scene_radiance_recovery (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pix_red, pix_green, pix_blue, transmission
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [2:0][7:0]       air_reg;
    logic                  boost_reg;
    logic                  low_reg;
    logic                  push, pop;
    hsrr_pkg::work_t       push_data, pop_data;
    hsrr_pkg::queue_stat_t q_stat;
    logic [2:0][7:0]       out_pix;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            air_reg   <= {8'd255, 8'd255, 8'd255};
            boost_reg <= 1'b0;
            low_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                hsrr_pkg::REG_AIR_RED:   air_reg[0] <= cfg_data;
                hsrr_pkg::REG_AIR_GREEN: air_reg[1] <= cfg_data;
                hsrr_pkg::REG_AIR_BLUE:  air_reg[2] <= cfg_data;
                hsrr_pkg::REG_BOOST:     boost_reg  <= cfg_data[0];
                hsrr_pkg::REG_LOW_LIGHT: low_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    hsrr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .pix_red        (s_tdata[7:0]),
        .pix_green      (s_tdata[15:8]),
        .pix_blue       (s_tdata[23:16]),
        .transmission   (s_tdata[39:24]),
        .airlight       (air_reg),
        .boost_enable   (boost_reg),
        .low_light_mode (low_reg),
        .q_stat         (q_stat),
        .push           (push),
        .push_data      (push_data)
    );

    hsrr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    hsrr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .q_data    (pop_data),
        .pop       (pop),
        .airlight  (air_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix)
    );

    assign m_tdata = {out_pix[2], out_pix[1], out_pix[0]};

endmodule

@@ hdl/hsrr_checker.sv @@
module hsrr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // reset empties the output
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // no item can reach the output right after reset release
    a_min_latency: assert property (@(posedge aclk)
        aresetn && $past(aresetn) && $past(aresetn, 2) && !$past(aresetn, 3) |-> !m_tvalid)
        else $error("output appeared too soon after reset");

    // a stalled item stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled item dropped");

    // a stalled item keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("stalled item changed");

    // input handshake is always known out of reset
    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_tvalid, s_tready}))
        else $error("input handshake unknown");

endmodule

bind haze_scene_radiance_recovery hsrr_checker u_hsrr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
